// ===== hw/rtl/hbd_pkg.sv =====
// hbd_pkg: shared types and constants of the huffman bit decoder
// used by hbd_table, hbd_ctrl, hbd_outbuf and huffman_bit_decoder; no dependencies
`default_nettype none

package hbd_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_CODE_LEN  = 16;
  localparam int BYTE_BITS     = 8;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int ACC_W   = MAX_CODE_LEN;
  localparam int ACCL_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int BITS_W  = $clog2(BYTE_BITS + 1);
  localparam int CODE_W  = 16;
  localparam int ELEN_W  = 5;
  localparam int CMP_W   = (ACC_W > CODE_W) ? ACC_W : CODE_W;
  localparam int LCMP_W  = (ACCL_W > ELEN_W) ? ACCL_W : ELEN_W;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_DATA    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  entry_index;
    logic [15:0] entry_code;
    logic [4:0]  entry_length;
    logic [7:0]  entry_symbol;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       done_res;
    logic       code_error;
  } out_word_t;

  typedef struct packed {
    logic [15:0] code;
    logic [4:0]  length;
    logic [7:0]  symbol;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } tbl_wr_t;

  // one decoded word from the sequencer, or the end of a data item
  typedef struct packed {
    logic       vld;
    logic       item_end;
    logic [7:0] symbol;
    logic       done_res;
    logic       code_error;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hbd_table.sv =====
// hbd_table: code table memory with one write and one registered read port,
// plus per-entry valid flops cleared by reset; depends on hbd_pkg
`default_nettype none

module hbd_table
  import hbd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tbl_wr_t          tbl_wr,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic                  rd_valid,
  output entry_t                rd_entry
);

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (tbl_wr.en) begin
      mem[tbl_wr.addr] <= tbl_wr.entry;
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (tbl_wr.en) begin
        valid[tbl_wr.addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hbd_ctrl.sv =====
// hbd_ctrl: bit sequencer and shared entry comparator, scans the table once per bit
// depends on hbd_pkg; drives hbd_table read and write ports
`default_nettype none

module hbd_ctrl
  import hbd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire in_word_t         item,
  input  wire logic [31:0]      symbol_total,
  output logic                  busy,
  output tbl_wr_t               tbl_wr,
  output logic [IDX_W-1:0]      rd_addr,
  input  wire logic             rd_valid,
  input  wire entry_t           rd_entry,
  output res_t                  res
);

  typedef enum logic [1:0] {S_IDLE, S_BIT, S_SCAN, S_FLUSH} state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t              state, state_next;
  logic [ACC_W-1:0]    acc_code, acc_code_next;
  logic [ACCL_W-1:0]   acc_length, acc_length_next;
  logic [31:0]         decoded_count, decoded_count_next;
  logic [7:0]          byte_sr, byte_sr_next;
  logic [BITS_W-1:0]   bits_left, bits_left_next;
  logic [IDX_W-1:0]    scan_addr, scan_addr_next;
  logic [IDX_W-1:0]    cmp_idx, cmp_idx_next;
  logic                cmp_vld, cmp_vld_next;
  logic                issue_done, issue_done_next;
  res_t                res_next;

  logic                accept;
  logic                hit;
  logic                padding;
  logic [31:0]         count_inc;
  logic [CMP_W-1:0]    code_mask;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign rd_addr = scan_addr;

  assign count_inc = decoded_count + 32'd1;
  assign padding   = (decoded_count >= symbol_total);
  assign code_mask = ~({CMP_W{1'b1}} << acc_length);
  assign hit = rd_valid
            && (LCMP_W'(rd_entry.length) == LCMP_W'(acc_length))
            && ((CMP_W'(rd_entry.code) & code_mask) == CMP_W'(acc_code));

  always_comb begin
    tbl_wr.en          = accept && (item.func == FUNC_LOAD)
                      && ({1'b0, item.entry_index} < 9'(TABLE_ENTRIES));
    tbl_wr.addr        = item.entry_index[IDX_W-1:0];
    tbl_wr.entry.code  = item.entry_code;
    tbl_wr.entry.length = item.entry_length;
    tbl_wr.entry.symbol = item.entry_symbol;
  end

  always_comb begin
    state_next         = state;
    acc_code_next      = acc_code;
    acc_length_next    = acc_length;
    decoded_count_next = decoded_count;
    byte_sr_next       = byte_sr;
    bits_left_next     = bits_left;
    scan_addr_next     = scan_addr;
    cmp_idx_next       = cmp_idx;
    cmp_vld_next       = cmp_vld;
    issue_done_next    = issue_done;
    res_next           = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.func == FUNC_RESTART) begin
            acc_code_next      = '0;
            acc_length_next    = '0;
            decoded_count_next = '0;
          end else if (item.func == FUNC_DATA) begin
            byte_sr_next   = item.data_byte;
            bits_left_next = BITS_W'(BYTE_BITS);
            state_next     = S_BIT;
          end
        end
      end
      S_BIT: begin
        if (bits_left == '0 || padding) begin
          state_next = S_FLUSH;
        end else begin
          acc_code_next   = ACC_W'({acc_code, byte_sr[7]});
          acc_length_next = acc_length + ACCL_W'(1);
          byte_sr_next    = {byte_sr[6:0], 1'b0};
          bits_left_next  = bits_left - BITS_W'(1);
          scan_addr_next  = '0;
          cmp_vld_next    = 1'b0;
          issue_done_next = 1'b0;
          state_next      = S_SCAN;
        end
      end
      S_SCAN: begin
        // reads stream one entry ahead of the compare stage
        if (cmp_vld && hit) begin
          res_next.vld       = 1'b1;
          res_next.symbol    = rd_entry.symbol;
          res_next.done_res  = (count_inc >= symbol_total);
          decoded_count_next = count_inc;
          acc_code_next      = '0;
          acc_length_next    = '0;
          state_next         = S_BIT;
        end else if (cmp_vld && cmp_idx == LAST_IDX) begin
          if (acc_length >= ACCL_W'(MAX_CODE_LEN)) begin
            res_next.vld        = 1'b1;
            res_next.code_error = 1'b1;
            res_next.done_res   = padding;
            acc_code_next       = '0;
            acc_length_next     = '0;
          end
          state_next = S_BIT;
        end else begin
          cmp_vld_next = !issue_done;
          cmp_idx_next = scan_addr;
          if (!issue_done) begin
            if (scan_addr == LAST_IDX) begin
              issue_done_next = 1'b1;
            end else begin
              scan_addr_next = scan_addr + IDX_W'(1);
            end
          end
        end
      end
      S_FLUSH: begin
        res_next.item_end = 1'b1;
        state_next        = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      acc_code      <= '0;
      acc_length    <= '0;
      decoded_count <= '0;
      bits_left     <= '0;
      cmp_vld       <= 1'b0;
      issue_done    <= 1'b0;
      res           <= '0;
    end else begin
      state         <= state_next;
      acc_code      <= acc_code_next;
      acc_length    <= acc_length_next;
      decoded_count <= decoded_count_next;
      bits_left     <= bits_left_next;
      cmp_vld       <= cmp_vld_next;
      issue_done    <= issue_done_next;
      res           <= res_next;
    end
    byte_sr   <= byte_sr_next;
    scan_addr <= scan_addr_next;
    cmp_idx   <= cmp_idx_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hbd_outbuf.sv =====
// hbd_outbuf: holds back one decoded word so the final word of a byte can be
// flagged as last; drives the output strobe; depends on hbd_pkg
`default_nettype none

module hbd_outbuf
  import hbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire res_t res,
  output logic      result_strobe,
  output out_word_t result,
  output logic      pend_vld
);

  out_word_t pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      pend_vld      <= 1'b0;
    end else begin
      if (res.vld) begin
        result_strobe <= pend_vld;
        if (pend_vld) begin
          result <= pend;
        end
        pend_vld        <= 1'b1;
        pend.symbol     <= res.symbol;
        pend.last       <= 1'b0;
        pend.done_res   <= res.done_res;
        pend.code_error <= res.code_error;
      end else if (res.item_end) begin
        // end of byte: the held word is the final one
        result_strobe <= pend_vld;
        if (pend_vld) begin
          result <= {pend.symbol, 1'b1, pend.done_res, pend.code_error};
        end
        pend_vld <= 1'b0;
      end else begin
        result_strobe <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/huffman_bit_decoder.sv =====
// channel   signals                         handshake
// command   start, busy, item               taken when start is high and busy is low
// result    result_strobe, result           one cycle per word, cannot be held off
// config    cfg_we, cfg_wdata               symbol_total written when cfg_we is high
//
// a load or restart word is taken without leaving idle, so busy stays low
// a data word keeps busy high; each bit
// scans the code table through its single read port, one entry per cycle
// the final result word of a byte appears in the cycle after busy falls
// rst is synchronous and clears the valid flags, accumulator, count and symbol_total
// depends on hbd_pkg, hbd_table, hbd_ctrl, hbd_outbuf
`default_nettype none

module huffman_bit_decoder
  import hbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_word_t    item,
  output logic             result_strobe,
  output out_word_t        result,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0]      symbol_total;
  tbl_wr_t          tbl_wr;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_valid;
  entry_t           rd_entry;
  res_t             res;
  logic             pend_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_total <= '0;
    end else if (cfg_we) begin
      symbol_total <= cfg_wdata;
    end
  end

  hbd_table u_table (
    .clk      (clk),
    .rst      (rst),
    .tbl_wr   (tbl_wr),
    .rd_addr  (rd_addr),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry)
  );

  hbd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .symbol_total (symbol_total),
    .busy         (busy),
    .tbl_wr       (tbl_wr),
    .rd_addr      (rd_addr),
    .rd_valid     (rd_valid),
    .rd_entry     (rd_entry),
    .res          (res)
  );

  hbd_outbuf u_outbuf (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .result_strobe (result_strobe),
    .result        (result),
    .pend_vld      (pend_vld)
  );

  // a data word always occupies the sequencer
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.func == FUNC_DATA) |=> busy)
    else $error("data word accepted without going busy");

  // no word may be left held back once the sequencer is idle and the byte end is out
  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !res.item_end) |-> !pend_vld)
    else $error("held result word while idle");

  // error words carry symbol zero
  a_err_sym: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.code_error) |-> (result.symbol == 8'd0 && !result.done_res))
    else $error("error word with nonzero symbol or done flag");

  // table writes happen only on an accepted load word
  a_wr_load: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> (start && !busy && item.func == FUNC_LOAD))
    else $error("table written outside a load word");

endmodule

`default_nettype wire

// ===== verif/huffman_bit_decoder_tb.sv =====
// huffman_bit_decoder_tb: self-checking bench for the huffman bit decoder
// drives table loads, restarts and compressed bytes, predicts every result word
// depends on hbd_pkg and huffman_bit_decoder
`timescale 1ns / 100ps

module huffman_bit_decoder_tb;
  import hbd_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEM_GOAL       = 290;
  localparam int PHASE_ITEMS     = 40;
  localparam int DRAIN_CYCLES    = 2100;
  localparam int WATCHDOG_CYCLES = 25000;
  localparam int MAX_LEAVES      = 32;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    item = '0;
  logic        result_strobe;
  out_word_t   result;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // decoder state as the bench expects it
  bit          tbl_valid [TABLE_ENTRIES];
  bit [15:0]   tbl_code [TABLE_ENTRIES];
  bit [4:0]    tbl_len [TABLE_ENTRIES];
  bit [7:0]    tbl_sym [TABLE_ENTRIES];
  bit [15:0]   acc_bits;
  int          acc_len;
  bit [31:0]   decoded_cnt;
  bit [31:0]   sym_total;

  in_word_t    command_words [$];
  out_word_t   decoded_words_due [$];

  bit          holding;
  bit          word_taken;
  bit          no_gaps;
  int          items_queued;
  int          items_accepted;
  int          results_checked;
  int          mismatches;
  int          settings_written;
  int          idle_run;

  // stimulus side: live table slots and the current prefix code
  bit          gen_live [TABLE_ENTRIES];
  bit [15:0]   leaf_code [MAX_LEAVES];
  int          leaf_len [MAX_LEAVES];
  int          leaf_slot [MAX_LEAVES];
  bit [7:0]    leaf_sym [MAX_LEAVES];
  int          n_leaves;

  huffman_bit_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void decode_item(input in_word_t w);
    out_word_t   words [8];
    int          n;
    int          b;
    int          i;
    int          hit_at;
    bit [15:0]   mask;
    n = 0;
    case (w.func)
      FUNC_LOAD: begin
        tbl_valid[w.entry_index] = 1'b1;
        tbl_code[w.entry_index]  = w.entry_code;
        tbl_len[w.entry_index]   = w.entry_length;
        tbl_sym[w.entry_index]   = w.entry_symbol;
      end
      FUNC_RESTART: begin
        acc_bits    = '0;
        acc_len     = 0;
        decoded_cnt = '0;
      end
      FUNC_DATA: begin
        for (b = BYTE_BITS - 1; b >= 0; b--) begin
          // padding once the symbol total is reached
          if (decoded_cnt >= sym_total) break;
          acc_bits = {acc_bits[14:0], w.data_byte[b]};
          acc_len++;
          mask = 16'((32'd1 << acc_len) - 32'd1);
          hit_at = -1;
          for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && int'(tbl_len[i]) == acc_len &&
                (tbl_code[i] & mask) == acc_bits) begin
              hit_at = i;
              break;
            end
          end
          if (hit_at >= 0) begin
            decoded_cnt++;
            words[n].symbol     = tbl_sym[hit_at];
            words[n].code_error = 1'b0;
          end else if (acc_len >= MAX_CODE_LEN) begin
            words[n].symbol     = 8'h00;
            words[n].code_error = 1'b1;
          end
          if (hit_at >= 0 || acc_len >= MAX_CODE_LEN) begin
            words[n].last     = 1'b0;
            words[n].done_res = (decoded_cnt >= sym_total);
            n++;
            acc_bits = '0;
            acc_len  = 0;
          end
        end
      end
      default: ;
    endcase
    for (i = 0; i < n; i++) begin
      if (i == n - 1) words[i].last = 1'b1;
      decoded_words_due.push_back(words[i]);
    end
  endfunction

  task automatic flag_mismatch(input string what, input out_word_t want, input out_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected sym %02h last %0d done %0d err %0d, got sym %02h last %0d done %0d err %0d",
               $time, what, want.symbol, want.last, want.done_res, want.code_error,
               got.symbol, got.last, got.done_res, got.code_error);
  endtask

  // driver: words change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (word_taken) begin
        holding    = 1'b0;
        word_taken = 1'b0;
      end
      if (!holding && command_words.size() > 0) begin
        item <= command_words.pop_front();
        holding = 1'b1;
      end
      start <= holding && (no_gaps || $urandom_range(99) >= 35);
    end
  end

  // monitor: results, accepted words and register writes on the rising edge
  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (result_strobe) begin
        results_checked++;
        if (decoded_words_due.size() == 0) begin
          flag_mismatch("unexpected result word", '0, result);
        end else begin
          want = decoded_words_due.pop_front();
          if (result.symbol !== want.symbol || result.last !== want.last ||
              result.done_res !== want.done_res || result.code_error !== want.code_error)
            flag_mismatch("result word mismatch", want, result);
        end
      end
      if (cfg_we) sym_total = cfg_wdata;
      if (start && !busy) begin
        decode_item(item);
        word_taken = 1'b1;
        items_accepted++;
      end
      if ((start && !busy) || result_strobe) idle_run = 0;
      else idle_run++;
      if (idle_run >= WATCHDOG_CYCLES) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_CYCLES);
        $display("huffman_bit_decoder verification failed");
        $finish;
      end
    end
  end

  function automatic in_word_t filler();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    filler = raw[$bits(in_word_t)-1:0];
  endfunction

  task automatic push_word(input in_word_t w);
    command_words.push_back(w);
    if (w.func != FUNC_UNUSED) items_queued++;
  endtask

  task automatic push_load(input bit [7:0] idx, input bit [15:0] code, input bit [4:0] len,
                           input bit [7:0] sym);
    in_word_t w;
    w = filler();
    w.func         = FUNC_LOAD;
    w.entry_index  = idx;
    w.entry_code   = code;
    w.entry_length = len;
    w.entry_symbol = sym;
    gen_live[idx] = (len != 0 && len <= MAX_CODE_LEN);
    push_word(w);
  endtask

  task automatic push_data(input bit [7:0] data);
    in_word_t w;
    w = filler();
    w.func      = FUNC_DATA;
    w.data_byte = data;
    push_word(w);
  endtask

  task automatic push_restart();
    in_word_t w;
    w = filler();
    w.func = FUNC_RESTART;
    push_word(w);
  endtask

  task automatic push_unused();
    in_word_t w;
    w = filler();
    w.func = FUNC_UNUSED;
    push_word(w);
  endtask

  // waits until nothing is queued, in flight or due, then lets a byte's worth pass
  task automatic settle();
    @(posedge clk);
    while (command_words.size() != 0 || holding || decoded_words_due.size() != 0 || busy)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(input bit [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  // complete prefix code by splitting leaves; chain gives lengths 1 up to 16
  task automatic build_code(input int n, input int max_len, input bit chain);
    int pick;
    n_leaves     = 1;
    leaf_code[0] = '0;
    leaf_len[0]  = 0;
    while (n_leaves < n) begin
      pick = chain ? n_leaves - 1 : $urandom_range(n_leaves - 1);
      if (leaf_len[pick] < max_len) begin
        leaf_code[n_leaves] = {leaf_code[pick][14:0], 1'b1};
        leaf_len[n_leaves]  = leaf_len[pick] + 1;
        leaf_code[pick]     = {leaf_code[pick][14:0], 1'b0};
        leaf_len[pick]++;
        n_leaves++;
      end
    end
  endtask

  task automatic load_table(input bit drop_one);
    bit keep [TABLE_ENTRIES];
    bit chosen [TABLE_ENTRIES];
    int s;
    int k;
    for (k = 0; k < n_leaves; k++) begin
      s = $urandom_range(TABLE_ENTRIES - 1);
      while (chosen[s]) s = $urandom_range(TABLE_ENTRIES - 1);
      chosen[s]    = 1'b1;
      leaf_slot[k] = s;
      leaf_sym[k]  = 8'($urandom);
    end
    // an incomplete code leaves bit patterns that end in a code error
    if (drop_one) leaf_slot[$urandom_range(n_leaves - 1)] = -1;
    for (k = 0; k < n_leaves; k++)
      if (leaf_slot[k] >= 0) keep[leaf_slot[k]] = 1'b1;
    for (s = 0; s < TABLE_ENTRIES; s++)
      if (gen_live[s] && !keep[s])
        push_load(8'(s), 16'($urandom),
                  ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(17, 31)), 8'($urandom));
    for (k = 0; k < n_leaves; k++)
      if (leaf_slot[k] >= 0)
        push_load(8'(leaf_slot[k]), leaf_code[k] | (16'($urandom) << leaf_len[k]),
                  5'(leaf_len[k]), leaf_sym[k]);
  endtask

  task automatic push_stream(input int nsym);
    bit [7:0] bits;
    int       fill;
    int       k;
    int       b;
    push_restart();
    bits = '0;
    fill = 0;
    repeat (nsym) begin
      k = $urandom_range(n_leaves - 1);
      while (leaf_slot[k] < 0) k = $urandom_range(n_leaves - 1);
      for (b = leaf_len[k] - 1; b >= 0; b--) begin
        bits = {bits[6:0], leaf_code[k][b]};
        fill++;
        if (fill == 8) begin
          push_data(bits);
          fill = 0;
        end
      end
    end
    if (fill > 0) begin
      while (fill < 8) begin
        bits = {bits[6:0], 1'($urandom)};
        fill++;
      end
      push_data(bits);
    end
  endtask

  initial begin
    bit [31:0] tot;
    int        phase;
    int        phase_end;
    int        pick;
    int        n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // symbol total still zero: every data bit is padding
    push_load(8'd255, 16'hFFFF, 5'd16, 8'hFF);
    push_load(8'd0, 16'hFFFE, 5'd1, 8'hA5);
    push_data(8'h00);
    push_unused();
    settle();
    write_total(32'hFFFF_FFFF);
    push_data(8'h00);
    // overwrite, duplicate codes, zero and oversize lengths
    push_load(8'd0, 16'hC0DE, 5'd2, 8'h3C);
    push_load(8'd1, 16'h0000, 5'd1, 8'h11);
    push_load(8'd2, 16'h5550, 5'd1, 8'h22);
    push_load(8'd3, 16'h0000, 5'd0, 8'h77);
    push_load(8'd4, 16'h0000, 5'd31, 8'h88);
    push_data(8'hFF);
    push_data(8'hFF);
    push_data(8'h80);
    // sixteen bits with no match
    push_data(8'hFF);
    push_data(8'h7F);
    // restart in the middle of a code
    push_data(8'hC0);
    push_restart();
    push_data(8'h00);
    settle();
    write_total(32'd3);
    push_restart();
    push_data(8'h00);
    push_data(8'h00);
    push_restart();
    push_data(8'h80);

    phase = 0;
    while (items_queued < ITEM_GOAL) begin
      case (phase)
        0:       tot = 32'd1;
        1:       tot = 32'hFFFF_FFFF;
        2:       tot = $urandom_range(2, 24);
        3:       tot = 32'd0;
        4:       tot = $urandom;
        default: tot = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 30);
      endcase
      settle();
      write_total(tot);
      no_gaps = (phase == 2);
      if (phase == 1) build_code(17, 16, 1'b1);
      else build_code($urandom_range(2, 12), $urandom_range(4, 16), 1'b0);
      load_table($urandom_range(3) == 0);
      phase_end = items_queued + PHASE_ITEMS;
      while (items_queued < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          if (tot != 0 && tot <= 30) begin
            n = int'(tot) + $urandom_range(4) - 2;
            if (n < 1) n = 1;
          end else begin
            n = $urandom_range(2, 20);
          end
          push_stream(n);
        end else if (pick < 85) begin
          push_data(8'($urandom));
        end else if (pick < 90) begin
          push_restart();
        end else if (pick < 95) begin
          push_unused();
        end else begin
          push_load(8'($urandom), 16'($urandom), 5'($urandom_range(1, 16)), 8'($urandom));
        end
      end
      phase++;
    end
    no_gaps = 1'b0;
    settle();

    $display("covered %0d command words over %0d symbol_total settings, %0d result words checked",
             items_accepted, settings_written, results_checked);
    if (decoded_words_due.size() != 0)
      $display("%0d expected result words never arrived", decoded_words_due.size());
    if (mismatches == 0 && decoded_words_due.size() == 0) begin
      $display("huffman_bit_decoder verification clean");
    end else begin
      $display("%0d mismatching result words", mismatches);
      $display("huffman_bit_decoder verification failed");
    end
    $finish;
  end

endmodule
